// ----- hdl/hrn_pkg.sv -----
`default_nettype none
package hrn_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;
  localparam int BURST_BITS  = 8;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int PROD_BITS   = TIME_BITS + 1 + BURST_BITS;

  typedef enum logic [1:0] {
    EV_DISPATCH = 2'd0,
    EV_FINISH   = 2'd1,
    EV_DROP     = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pid;
    logic [15:0] time_v;
    logic [15:0] wait_v;
    logic        last;
  } event_t;

  // controller -> datapath
  typedef struct packed {
    logic                 take_in;
    logic                 scan_clr;
    logic                 scan_step;
    logic [SLOT_BITS-1:0] scan_idx;
    logic                 do_finish;
    logic                 do_dispatch;
    logic                 tick_end;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;
    logic fin;
    logic cpu_busy;
    logic found;
    logic pending;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- hdl/hrn_if.sv -----
`default_nettype none
interface hrn_in_if;
  logic       valid;
  logic       ready;
  logic       arrival_valid;
  logic [7:0] arrival_pid;
  logic [7:0] arrival_burst;
  modport source (output valid, arrival_valid, arrival_pid, arrival_burst, input ready);
  modport sink   (input valid, arrival_valid, arrival_pid, arrival_burst, output ready);
endinterface

interface hrn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  event_pid;
  logic [15:0] event_time;
  logic [15:0] wait_ticks;
  logic        last;
  modport source (output valid, event_kind, event_pid, event_time, wait_ticks, last,
                  input ready);
  modport sink   (input valid, event_kind, event_pid, event_time, wait_ticks, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/hrn_datapath.sv -----
`default_nettype none
module hrn_datapath
  import hrn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  input  wire logic       arr_v,
  input  wire logic [7:0] arr_pid,
  input  wire logic [7:0] arr_burst,
  output dp_sts_t         sts,
  output logic [7:0]      drop_pid,
  output logic [7:0]      run_pid,
  output logic [15:0]     run_wait16,
  output logic [15:0]     now16
);
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [7:0]            pid_r   [QUEUE_DEPTH];
  logic [BURST_BITS-1:0] burst_r [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  arr_r   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  now_r, run_exit_r, run_wait_r, bw_r;
  logic [BURST_BITS-1:0] bb_r;
  logic [SLOT_BITS-1:0]  best_r;
  logic                  found_r, busy_r;
  logic [7:0]            run_pid_r, drop_pid_r;
  logic                  drop_r;

  logic [SLOT_BITS-1:0]  free_idx;
  logic                  free_any;
  logic [BURST_BITS-1:0] in_b;
  logic [TIME_BITS-1:0]  w;
  logic [BURST_BITS-1:0] b;
  logic [PROD_BITS-1:0]  lhs, rhs;
  logic                  better;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  assign in_b = (arr_burst[BURST_BITS-1:0] == '0) ? BURST_BITS'(1) : arr_burst[BURST_BITS-1:0];
  assign w   = now_r - arr_r[cmd.scan_idx];
  assign b   = burst_r[cmd.scan_idx];
  // one slot a cycle; cross products against the current best
  assign lhs = PROD_BITS'({1'b0, w} + (TIME_BITS+1)'(b)) * PROD_BITS'(bb_r);
  assign rhs = PROD_BITS'({1'b0, bw_r} + (TIME_BITS+1)'(bb_r)) * PROD_BITS'(b);
  assign better = !found_r || (lhs > rhs) || ((lhs == rhs) && (w > bw_r));

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.take_in && arr_v && free_any) valid_nxt[free_idx] = 1'b1;
    if (cmd.do_dispatch && found_r) valid_nxt[best_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      now_r <= '0;
      busy_r <= 1'b0;
      run_pid_r <= '0;
      run_exit_r <= '0;
      run_wait_r <= '0;
      found_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.take_in) begin
        drop_r <= arr_v && !free_any;
        drop_pid_r <= arr_pid;
        if (arr_v && free_any) begin
          pid_r[free_idx]   <= arr_pid;
          burst_r[free_idx] <= in_b;
          arr_r[free_idx]   <= now_r;
        end
      end
      if (cmd.do_finish) busy_r <= 1'b0;
      if (cmd.scan_clr) found_r <= 1'b0;
      if (cmd.scan_step && valid_r[cmd.scan_idx] && better) begin
        found_r <= 1'b1;
        best_r  <= cmd.scan_idx;
        bw_r    <= w;
        bb_r    <= b;
      end
      if (cmd.do_dispatch && found_r) begin
        busy_r     <= 1'b1;
        run_pid_r  <= pid_r[best_r];
        run_wait_r <= bw_r;
        run_exit_r <= now_r + TIME_BITS'(bb_r);
      end
      if (cmd.tick_end) now_r <= now_r + 1'b1;
    end
  end

  assign sts.drop     = drop_r;
  assign sts.fin      = busy_r && (run_exit_r == now_r);
  assign sts.cpu_busy = busy_r;
  assign sts.found    = found_r;
  assign sts.pending  = |valid_r;
  assign drop_pid     = drop_pid_r;
  assign run_pid      = (cmd.do_dispatch) ? pid_r[best_r] : run_pid_r;
  assign run_wait16   = 16'(run_wait_r);
  assign now16        = 16'(now_r);
endmodule
`default_nettype wire

// ----- hdl/hrn_ctrl.sv -----
`default_nettype none
module hrn_ctrl
  import hrn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    ev_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         in_rdy,
  output logic         ev_load,
  output logic [1:0]   ev_kind,
  output logic         ev_last
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DROP = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_DISP = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_END  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SLOT_BITS-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.scan_idx = idx_r;
    in_rdy  = 1'b0;
    ev_load = 1'b0;
    ev_kind = EV_DISPATCH;
    ev_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.take_in = 1'b1;
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (!sts.drop) state_nxt = S_FIN;
        else if (ev_ready) begin
          ev_load = 1'b1;
          ev_kind = EV_DROP;
          ev_last = !sts.fin && sts.cpu_busy;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.fin) begin
          state_nxt = sts.cpu_busy ? S_END : S_SCAN;
          cmd.scan_clr = 1'b1;
          idx_nxt = '0;
        end else if (ev_ready) begin
          ev_load = 1'b1;
          ev_kind = EV_FINISH;
          // an empty queue means no dispatch follows
          ev_last = !sts.pending;
          cmd.do_finish = 1'b1;
          cmd.scan_clr = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SLOT_BITS'(QUEUE_DEPTH - 1)) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (!sts.found) state_nxt = S_EMIT;
        else if (ev_ready) begin
          cmd.do_dispatch = 1'b1;
          ev_load = 1'b1;
          ev_kind = EV_DISPATCH;
          ev_last = 1'b1;
          state_nxt = S_END;
        end
      end
      S_EMIT: state_nxt = S_END;
      S_END: begin
        cmd.tick_end = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> state_r == S_IDLE)
    else $error("transfer outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_dispatch |-> !sts.cpu_busy) else $error("dispatch while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_in, cmd.scan_step, cmd.tick_end})) else $error("command clash");
endmodule
`default_nettype wire

// ----- hdl/hrn_scheduler_top.sv -----
`default_nettype none
// channel | dir | payload
// in_     | in  | arrival_valid, arrival_pid, arrival_burst (one tick)
// out_    | out | event_kind, event_pid, event_time, wait_ticks, last
// A tick with the CPU free steps through idle, drop, finish, a scan of all
// slots, dispatch and end (and emit when no job is ready); the scan compares
// one slot a cycle by cross-multiplication. A job that carries on skips the scan.
// Events leave through a single output register; a full register stalls the
// controller. Reset clears the queue, clock and CPU state at once.
module hrn_scheduler_top
  import hrn_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  hrn_in_if.sink   in_ch,
  hrn_out_if.source out_ch
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic in_rdy, ev_load, ev_last;
  logic [1:0] ev_kind;
  logic [7:0] drop_pid, run_pid;
  logic [15:0] run_wait16, now16;
  logic ov_r;
  event_t ev_r;
  logic ev_ready;

  assign ev_ready = !ov_r || out_ch.ready;
  assign in_ch.ready = in_rdy;

  hrn_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_ch.valid && in_rdy), .ev_ready, .sts, .cmd,
    .in_rdy, .ev_load, .ev_kind, .ev_last
  );

  hrn_datapath u_dp (
    .clk, .rst_n, .cmd, .arr_v(in_ch.arrival_valid), .arr_pid(in_ch.arrival_pid),
    .arr_burst(in_ch.arrival_burst), .sts, .drop_pid, .run_pid, .run_wait16, .now16
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ev_load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    if (ev_load) begin
      ev_r.kind   <= ev_kind;
      ev_r.time_v <= now16;
      ev_r.last   <= ev_last;
      ev_r.pid    <= (ev_kind == EV_DROP) ? drop_pid : run_pid;
      ev_r.wait_v <= (ev_kind == EV_FINISH) ? run_wait16 : 16'd0;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.event_kind = ev_r.kind;
  assign out_ch.event_pid  = ev_r.pid;
  assign out_ch.event_time = ev_r.time_v;
  assign out_ch.wait_ticks = ev_r.wait_v;
  assign out_ch.last       = ev_r.last;
endmodule
`default_nettype wire
